FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; expects clk and rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/pws_pkg.sv
// constants and codes for the periodic waveform synthesiser
// no dependencies
package pws_pkg;

  localparam int SampleBits = 16;
  localparam int PhaseBits  = 32;
  localparam int PeriodBits = 24;

  // register indexes
  localparam logic [3:0] REG_KIND    = 4'd0;
  localparam logic [3:0] REG_AMP     = 4'd1;
  localparam logic [3:0] REG_PERIOD  = 4'd2;
  localparam logic [3:0] REG_HIGH    = 4'd3;
  localparam logic [3:0] REG_PSTEP   = 4'd4;
  localparam logic [3:0] REG_PSTART  = 4'd5;
  localparam logic [3:0] REG_SWEEP   = 4'd6;
  localparam logic [3:0] REG_RECTIFY = 4'd7;

  // wave kinds
  localparam logic [2:0] KIND_DC     = 3'd0;
  localparam logic [2:0] KIND_SINE   = 3'd1;
  localparam logic [2:0] KIND_SQUARE = 3'd2;
  localparam logic [2:0] KIND_SAW    = 3'd3;
  localparam logic [2:0] KIND_CHIRP  = 3'd4;

  // rectify modes
  localparam logic [1:0] RECT_NONE = 2'd0;
  localparam logic [1:0] RECT_ABS  = 2'd1;
  localparam logic [1:0] RECT_POS  = 2'd2;

  // multiplier step codes
  localparam logic [2:0] STEP_X2  = 3'd0;
  localparam logic [2:0] STEP_C7  = 3'd1;
  localparam logic [2:0] STEP_C5  = 3'd2;
  localparam logic [2:0] STEP_C3  = 3'd3;
  localparam logic [2:0] STEP_R   = 3'd4;
  localparam logic [2:0] STEP_AMP = 3'd5;
  localparam logic [2:0] STEP_SAW = 3'd6;

  // sine polynomial coefficients, q30
  localparam logic [31:0] CA1 = 32'd1686629713;
  localparam logic [31:0] CA3 = 32'd693598668;
  localparam logic [31:0] CA5 = 32'd85569306;
  localparam logic [31:0] CA7 = 32'd5026995;

endpackage

FILE: hw/rtl/periodic_waveform_synth_unit.sv
// periodic waveform synthesiser: dc, sine, square, saw and chirp stimulus
// depends on pws_pkg and assert_macros.svh
//
// usage: each input word on s_axis (s_tdata[0] = restart) asks for one sample,
// delivered on m_axis (m_tdata = sample, m_tuser = period_begin).
// configuration writes come on cfg_valid/cfg_index/cfg_data, always ready;
// the user must make them only while no word is in flight (not enforced here).
// s_tready is high only while the sequencer is idle; one word is worked at
// a time. dc, square and unused kinds go from prep straight to fin; saw adds
// a product on the shared multiplier, sine (nonzero step) and chirp a chain of
// products (x2, c7, c5, c3, r, amp). a restart word first runs one or two
// bit-serial slope divisions. s_tready returns only once the sample is in
// the output register, so no new word is taken before the last one is through.
// the finished sample waits in the output register; while the receiver
// stalls the next word is still accepted and worked, then held until the
// output register frees.
// reset (rst, synchronous) loads register defaults, clears position, phase
// and slopes, and empties the output register.
`include "assert_macros.svh"

module periodic_waveform_synth_unit
  import pws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample
  output logic        m_tuser,   // [0] period_begin
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_PREP, ST_MUL, ST_FIN} state_t;

  state_t state;

  // configuration registers
  logic [2:0]  wave_kind;
  logic signed [15:0] amplitude;
  logic [23:0] period_samples, high_samples;
  logic [31:0] phase_step, phase_start, sweep_step;
  logic [1:0]  rectify_mode;

  // generator state
  logic [23:0] pos;
  logic [31:0] phase, cur_step;
  logic        rise_neg, fall_neg;
  logic [31:0] rise_mag, fall_mag;

  // work registers
  logic        div_fall;
  logic [4:0]  div_cnt;
  logic [23:0] div_d, rem;
  logic [31:0] quo;
  logic [2:0]  step;
  logic        mwait;
  logic [56:0] prod;
  logic [16:0] x_r, x2_r;
  logic [31:0] s_r, slope_r;
  logic [23:0] n_r;
  logic        neg_r, dc_r, begin_r;
  logic signed [42:0] val;

  // combinational helpers
  logic [15:0] mag_amp;
  logic [24:0] rem_sh;
  logic        ge;
  logic [23:0] rem_next;
  logic [31:0] quo_next;
  logic [31:0] mul_a;
  logic [24:0] mul_b;
  logic [23:0] pos_eff;
  logic [24:0] pos_inc;
  logic [16:0] x_of;
  logic [56:0] rnd_amp, rnd_saw;
  logic signed [42:0] amp_w, half_amp, rect, sat_in;
  logic [15:0] sat;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign mag_amp   = amplitude[15] ? 16'(-amplitude) : 16'(amplitude);
  assign amp_w     = 43'(amplitude);
  assign half_amp  = (amp_w + $signed({42'd0, amplitude[15]})) >>> 1;

  // divider step
  assign rem_sh   = {rem, quo[31]};
  assign ge       = rem_sh >= {1'b0, div_d};
  assign rem_next = ge ? 24'(rem_sh - {1'b0, div_d}) : rem_sh[23:0];
  assign quo_next = {quo[30:0], ge};

  // position and sine argument
  assign pos_eff = (pos >= period_samples) ? '0 : pos;
  assign pos_inc = {1'b0, pos_eff} + 25'd1;
  assign x_of    = phase[30] ? 17'(17'd65536 - {1'b0, phase[29:14]})
                             : {1'b0, phase[29:14]};

  // shared multiplier operands
  always_comb begin
    unique case (step)
      STEP_X2:  begin mul_a = 32'(x_r);  mul_b = 25'(x_r);   end
      STEP_C7:  begin mul_a = CA7;       mul_b = 25'(x2_r);  end
      STEP_C5:  begin mul_a = s_r;       mul_b = 25'(x2_r);  end
      STEP_C3:  begin mul_a = s_r;       mul_b = 25'(x2_r);  end
      STEP_R:   begin mul_a = s_r;       mul_b = 25'(x_r);   end
      STEP_AMP: begin mul_a = s_r;       mul_b = 25'(mag_amp); end
      STEP_SAW: begin mul_a = slope_r;   mul_b = 25'(n_r);   end
      default:  begin mul_a = '0;        mul_b = '0;         end
    endcase
  end

  assign rnd_amp = prod + 57'(1 << 29);
  assign rnd_saw = prod + 57'd16384;

  // rectify and saturate
  always_comb begin
    rect = val;
    if (rectify_mode == RECT_ABS || (rectify_mode == RECT_POS && dc_r)) begin
      if (val < 0) rect = -val;
    end else if (rectify_mode == RECT_POS && val < 0) begin
      rect = '0;
    end
    sat_in = rect;
    if (sat_in > 43'sd32767) sat = 16'h7fff;
    else if (sat_in < -43'sd32768) sat = 16'h8000;
    else sat = sat_in[15:0];
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_kind <= KIND_DC; amplitude <= '0;
      period_samples <= 24'd1000; high_samples <= 24'd500;
      phase_step <= '0; phase_start <= '0; sweep_step <= '0;
      rectify_mode <= RECT_NONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KIND:    wave_kind      <= cfg_data[2:0];
        REG_AMP:     amplitude      <= cfg_data[15:0];
        REG_PERIOD:  period_samples <= cfg_data[23:0];
        REG_HIGH:    high_samples   <= cfg_data[23:0];
        REG_PSTEP:   phase_step     <= cfg_data;
        REG_PSTART:  phase_start    <= cfg_data;
        REG_SWEEP:   sweep_step     <= cfg_data;
        REG_RECTIFY: rectify_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= 57'(mul_a * mul_b);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; m_tvalid <= 1'b0;
      pos <= '0; phase <= '0; cur_step <= '0;
      rise_neg <= 1'b0; fall_neg <= 1'b0; rise_mag <= '0; fall_mag <= '0;
      div_fall <= 1'b0; div_cnt <= '0; step <= STEP_X2; mwait <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tdata[0]) begin
              pos <= '0; phase <= phase_start; cur_step <= phase_step;
              rem <= '0; quo <= {mag_amp, 16'd0}; div_d <= high_samples;
              div_fall <= 1'b0; div_cnt <= '0;
              state <= ST_DIV;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_next; quo <= quo_next; div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            if (!div_fall) begin
              rise_mag <= (high_samples == '0) ? '0 : quo_next;
              rise_neg <= amplitude[15];
              fall_neg <= amplitude[15];
              if (high_samples < period_samples) begin
                rem <= '0; quo <= {mag_amp, 16'd0};
                div_d <= period_samples - high_samples;
                div_fall <= 1'b1;
              end else begin
                fall_mag <= '0;
                state <= ST_PREP;
              end
            end else begin
              fall_mag <= quo_next;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          dc_r <= 1'b0; begin_r <= 1'b0; val <= '0; mwait <= 1'b0;
          x_r <= x_of; neg_r <= amplitude[15] ^ phase[31];
          if (period_samples != '0)
            pos <= (pos_inc >= {1'b0, period_samples}) ? '0 : pos_inc[23:0];
          else
            pos <= pos_eff;
          state <= ST_FIN;
          unique case (wave_kind)
            KIND_DC: begin
              val <= amp_w; dc_r <= 1'b1;
            end
            KIND_SINE: begin
              phase <= phase + phase_step;
              if (phase_step == '0) begin
                val <= amp_w; dc_r <= 1'b1;
              end else begin
                step <= STEP_X2; state <= ST_MUL;
              end
            end
            KIND_SQUARE, KIND_SAW: begin
              if (period_samples == '0) begin
                val <= half_amp; dc_r <= 1'b1;
              end else begin
                begin_r <= (pos_eff == '0);
                if (wave_kind == KIND_SQUARE) begin
                  val <= (pos_eff < high_samples) ? amp_w : -amp_w;
                end else begin
                  step <= STEP_SAW; state <= ST_MUL;
                  if (pos_eff <= high_samples) begin
                    slope_r <= rise_mag; neg_r <= rise_neg; n_r <= pos_eff;
                  end else begin
                    slope_r <= fall_mag; neg_r <= fall_neg;
                    n_r <= period_samples - pos_eff;
                  end
                end
              end
            end
            KIND_CHIRP: begin
              phase <= phase + cur_step;
              cur_step <= cur_step + sweep_step;
              step <= STEP_X2; state <= ST_MUL;
            end
            default: val <= '0;
          endcase
        end
        ST_MUL: begin
          mwait <= !mwait;
          if (mwait) begin
            step <= step + 3'd1;
            unique case (step)
              STEP_X2: x2_r <= prod[32:16];
              STEP_C7: s_r <= CA5 - prod[47:16];
              STEP_C5: s_r <= CA3 - prod[47:16];
              STEP_C3: s_r <= CA1 - prod[47:16];
              STEP_R:  s_r <= prod[47:16];
              STEP_AMP: begin
                val <= neg_r ? -43'(rnd_amp[56:30]) : 43'(rnd_amp[56:30]);
                state <= ST_FIN;
              end
              STEP_SAW: begin
                val <= (neg_r ? -43'(rnd_saw[55:15]) : 43'(rnd_saw[55:15])) - amp_w;
                state <= ST_FIN;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sat;
            m_tuser  <= begin_r;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_NXT(a_restart_divides, s_tvalid && s_tready && s_tdata[0], state == ST_DIV)
  `ASSERT_IMP(a_step_range, state == ST_MUL, step <= STEP_SAW)
  `ASSERT_IMP(a_out_from_fin, $rose(m_tvalid), $past(state == ST_FIN))
  `ASSERT_IMP(a_pos_in_period, state == ST_PREP && period_samples != '0,
              pos_eff < period_samples)

endmodule
